// File: hdl/video_port_access_with_dma_assert.svh
// ----------------------------------------------------------------------------
// Video port assertion macros
// Implication checks on the top level clock and reset.
// ----------------------------------------------------------------------------
`ifndef VIDEO_PORT_ACCESS_WITH_DMA_ASSERT_SVH
`define VIDEO_PORT_ACCESS_WITH_DMA_ASSERT_SVH

// same-cycle implication
`define VPA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("video port assertion failed");

// next-cycle implication
`define VPA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("video port assertion failed");

`endif

// File: hdl/vpa_pkg.sv
// ----------------------------------------------------------------------------
// Video port package
// Sizes, codes and transfer types shared by the video port modules.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int VIDEO_BYTES    = 65536;
    localparam int COLOR_BYTES    = 128;
    localparam int SCROLL_BYTES   = 128;
    localparam int REGISTER_COUNT = 32;

    localparam int VID_AW = $clog2(VIDEO_BYTES);
    localparam int COL_AW = $clog2(COLOR_BYTES);
    localparam int SCR_AW = $clog2(SCROLL_BYTES);
    localparam int REG_AW = $clog2(REGISTER_COUNT);

    localparam logic [2:0] FN_CTRL    = 3'd0;
    localparam logic [2:0] FN_WR_WORD = 3'd1;
    localparam logic [2:0] FN_WR_BYTE = 3'd2;
    localparam logic [2:0] FN_RD_WORD = 3'd3;
    localparam logic [2:0] FN_RD_BYTE = 3'd4;
    localparam logic [2:0] FN_REG_WR  = 3'd5;

    localparam logic [6:0] AC_VID_WR = 7'h04;
    localparam logic [6:0] AC_COL_WR = 7'h0c;
    localparam logic [6:0] AC_SCR_WR = 7'h14;
    localparam logic [6:0] AC_VID_RD = 7'h00;
    localparam logic [6:0] AC_COL_RD = 7'h20;
    localparam logic [6:0] AC_SCR_RD = 7'h10;

    localparam int REG_INC     = 15;
    localparam int REG_LEN_LO  = 19;
    localparam int REG_LEN_HI  = 20;
    localparam int REG_SRC_LO  = 21;
    localparam int REG_SRC_MID = 22;
    localparam int REG_SRC_HI  = 23;

    localparam logic [1:0] DMA_FILL = 2'd2;
    localparam logic [1:0] DMA_COPY = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] value;
        logic [4:0]  reg_num;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [7:0]  dirty_flags;
        logic        command_pending;
    } result_t;

    typedef struct packed {
        logic        vid_we;
        logic        col_we;
        logic        scr_we;
        logic [15:0] addr;
        logic [7:0]  data;
    } mem_wr_t;

    typedef struct packed {
        logic [7:0] vid_q;
        logic [7:0] col_q;
        logic [7:0] scr_q;
    } mem_rd_t;

    typedef struct packed {
        logic       we;
        logic [4:0] idx;
        logic [7:0] data;
    } reg_wr_t;

    typedef struct packed {
        logic [7:0]  inc;
        logic [15:0] len;
        logic [15:0] src;
        logic [1:0]  mode;
    } reg_tap_t;

endpackage

// File: hdl/video_port_access_with_dma.sv
// ----------------------------------------------------------------------------
// Video port access with DMA
// Control/data port sequencer over video, color and scroll memories.
// ----------------------------------------------------------------------------
// Usage: drive item and raise start; the transfer is taken on a clock edge
// with start high and busy low. One result per item appears on result for
// exactly one cycle with done high; the receiver cannot stall it.
// Cycles from accept to done, all through one byte write/read memory port:
//   control word, register write, dropped write: 1
//   byte write: 2, word write: 3, byte read: 3, word read: 4
//   DMA fill: 1 + len (byte) or 1 + 2*len (word)
//   DMA copy: 1 + 5*len (two reads and two writes per word)
// busy is high from the accept edge until the cycle of done; one-cycle items
// never raise it. One item at a time.
// Reset: after rst_n rises a clearing pass zeroes the memories, one video
// address per cycle, VIDEO_BYTES (65536) cycles, with busy high throughout.
// Registers reset to zero, the dirty byte to all ones.
// ----------------------------------------------------------------------------
`include "video_port_access_with_dma_assert.svh"

module video_port_access_with_dma (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  vpa_pkg::item_t   item,
    output logic             done,
    output vpa_pkg::result_t result
);
    import vpa_pkg::*;

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_WR0   = 10'b0000000100,
        ST_WR1   = 10'b0000001000,
        ST_RD0   = 10'b0000010000,
        ST_RD1   = 10'b0000100000,
        ST_RD2   = 10'b0001000000,
        ST_CP0   = 10'b0010000000,
        ST_CP1   = 10'b0100000000,
        ST_CP2   = 10'b1000000000
    } state_t;

    state_t              state_reg,   state_next;
    logic [15:0]         addr_reg,    addr_next;
    logic [6:0]          code_reg,    code_next;
    logic                pending_reg, pending_next;
    logic                dma_reg,     dma_next;
    logic [7:0]          dirty_reg,   dirty_next;
    logic [15:0]         cnt_reg,     cnt_next;
    logic [15:0]         src_reg,     src_next;
    logic [15:0]         word_reg,    word_next;
    logic                bmode_reg,   bmode_next;
    logic                copy_reg,    copy_next;
    logic                wide_reg,    wide_next;
    logic [VID_AW-1:0]   clr_reg,     clr_next;
    logic [15:0]         rdata_reg,   rdata_next;
    logic                done_reg,    done_next;

    mem_wr_t     mem_wr;
    mem_rd_t     mem_rd;
    logic [15:0] raddr;
    reg_wr_t     reg_wr;
    reg_tap_t    taps;

    logic        vid_sel;
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [7:0]  rd_sel;
    logic [15:0] addr_adv;

    vpa_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (raddr),
        .rd    (mem_rd)
    );

    vpa_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (reg_wr),
        .taps  (taps)
    );

    assign vid_sel     = (code_reg == AC_VID_WR);
    assign byte_first  = (bmode_reg || (vid_sel && addr_reg[0])) ? word_reg[7:0]
                                                                  : word_reg[15:8];
    assign byte_second = (vid_sel && addr_reg[0]) ? word_reg[15:8] : word_reg[7:0];
    assign addr_adv    = addr_reg + {8'h00, taps.inc};

    always_comb
    begin
        case (code_reg)
            AC_VID_RD: rd_sel = mem_rd.vid_q;
            AC_COL_RD: rd_sel = mem_rd.col_q;
            AC_SCR_RD: rd_sel = mem_rd.scr_q;
            default:   rd_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        code_next    = code_reg;
        pending_next = pending_reg;
        dma_next     = dma_reg;
        dirty_next   = dirty_reg;
        cnt_next     = cnt_reg;
        src_next     = src_reg;
        word_next    = word_reg;
        bmode_next   = bmode_reg;
        copy_next    = copy_reg;
        wide_next    = wide_reg;
        clr_next     = clr_reg;
        rdata_next   = rdata_reg;
        done_next    = 1'b0;
        mem_wr       = '0;
        raddr        = addr_reg;
        reg_wr       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr.vid_we = 1'b1;
                mem_wr.col_we = 1'b1;
                mem_wr.scr_we = 1'b1;
                mem_wr.addr   = 16'(clr_reg);
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == VID_AW'(VIDEO_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    rdata_next = 16'h0000;
                    case (item.func)
                        FN_CTRL:
                        begin
                            if (!pending_reg)
                            begin
                                addr_next    = {addr_reg[15:14], item.value[13:0]};
                                code_next    = {3'b000, item.value[15:14], 2'b00};
                                dma_next     = 1'b0;
                                pending_next = 1'b1;
                                done_next    = 1'b1;
                            end
                            else
                            begin
                                addr_next    = {item.value[1:0], addr_reg[13:0]};
                                code_next    = code_reg | {item.value[6:4], 4'b0000};
                                dma_next     = item.value[7];
                                pending_next = 1'b0;
                                if (item.value[7] && (taps.mode == DMA_COPY)
                                    && (taps.len != 16'h0000))
                                begin
                                    src_next   = taps.src;
                                    cnt_next   = taps.len;
                                    copy_next  = 1'b1;
                                    bmode_next = 1'b0;
                                    state_next = ST_CP0;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                        FN_WR_WORD, FN_WR_BYTE:
                        begin
                            word_next  = item.value;
                            bmode_next = (item.func == FN_WR_BYTE);
                            copy_next  = 1'b0;
                            if (!dma_reg)
                            begin
                                cnt_next   = 16'h0001;
                                state_next = ST_WR0;
                            end
                            else if ((taps.mode == DMA_FILL) && (taps.len != 16'h0000))
                            begin
                                cnt_next   = taps.len;
                                state_next = ST_WR0;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        FN_RD_WORD, FN_RD_BYTE:
                        begin
                            wide_next  = (item.func == FN_RD_WORD);
                            state_next = ST_RD0;
                        end
                        FN_REG_WR:
                        begin
                            reg_wr.we   = 1'b1;
                            reg_wr.idx  = item.reg_num;
                            reg_wr.data = item.value[7:0];
                            code_next   = 7'h00;
                            done_next   = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_WR0:
            begin
                mem_wr.vid_we = vid_sel;
                mem_wr.col_we = (code_reg == AC_COL_WR);
                mem_wr.scr_we = (code_reg == AC_SCR_WR);
                mem_wr.addr   = addr_reg;
                mem_wr.data   = byte_first;
                if (bmode_reg)
                begin
                    addr_next = addr_adv;
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == 16'h0001)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_WR1;
                end
            end
            ST_WR1:
            begin
                mem_wr.vid_we = vid_sel;
                mem_wr.col_we = (code_reg == AC_COL_WR);
                mem_wr.scr_we = (code_reg == AC_SCR_WR);
                mem_wr.addr   = addr_reg + 16'h0001;
                mem_wr.data   = byte_second;
                addr_next     = addr_adv;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == 16'h0001)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = copy_reg ? ST_CP0 : ST_WR0;
                end
            end
            ST_RD0:
            begin
                raddr = addr_reg;
                if (wide_reg)
                begin
                    state_next = ST_RD1;
                end
                else
                begin
                    rdata_next = 16'h0000;
                    state_next = ST_RD2;
                end
            end
            ST_RD1:
            begin
                raddr            = addr_reg + 16'h0001;
                rdata_next[15:8] = rd_sel;
                state_next       = ST_RD2;
            end
            ST_RD2:
            begin
                rdata_next[7:0] = rd_sel;
                addr_next       = addr_adv;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_CP0:
            begin
                raddr      = src_reg;
                state_next = ST_CP1;
            end
            ST_CP1:
            begin
                raddr           = src_reg + 16'h0001;
                word_next[15:8] = mem_rd.vid_q;
                src_next        = src_reg + 16'h0002;
                state_next      = ST_CP2;
            end
            ST_CP2:
            begin
                word_next[7:0] = mem_rd.vid_q;
                state_next     = ST_WR0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // bits are already set from reset; OR on every write keeps the byte exact
        if (state_reg != ST_CLEAR)
        begin
            dirty_next = dirty_next | {5'b00000, mem_wr.scr_we, mem_wr.col_we, mem_wr.vid_we};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= 16'h0000;
            code_reg    <= 7'h00;
            pending_reg <= 1'b0;
            dma_reg     <= 1'b0;
            dirty_reg   <= 8'hff;
            cnt_reg     <= 16'h0000;
            copy_reg    <= 1'b0;
            bmode_reg   <= 1'b0;
            wide_reg    <= 1'b0;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            code_reg    <= code_next;
            pending_reg <= pending_next;
            dma_reg     <= dma_next;
            dirty_reg   <= dirty_next;
            cnt_reg     <= cnt_next;
            copy_reg    <= copy_next;
            bmode_reg   <= bmode_next;
            wide_reg    <= wide_next;
            clr_reg     <= clr_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        word_reg  <= word_next;
        rdata_reg <= rdata_next;
    end

    assign busy                   = (state_reg != ST_IDLE);
    assign done                   = done_reg;
    assign result.read_data       = rdata_reg;
    assign result.dirty_flags     = dirty_reg;
    assign result.command_pending = pending_reg;

    `VPA_ASSERT_NXT(a_accept_busy_or_done, start && !busy, busy || done)
    `VPA_ASSERT_IMP(a_done_idle, done, !busy)
    `VPA_ASSERT_IMP(a_done_cause, done, $past(busy) || $past(start))
    `VPA_ASSERT_IMP(a_clear_no_done, state_reg == ST_CLEAR, !done)

endmodule

// File: hdl/vpa_mem.sv
// ----------------------------------------------------------------------------
// Video port memories
// Video, color and scroll byte memories: one write and one registered read.
// ----------------------------------------------------------------------------
module vpa_mem (
    input  logic             clk,
    input  vpa_pkg::mem_wr_t wr,
    input  logic [15:0]      raddr,
    output vpa_pkg::mem_rd_t rd
);
    import vpa_pkg::*;

    logic [7:0] vid_mem [VIDEO_BYTES];
    logic [7:0] col_mem [COLOR_BYTES];
    logic [7:0] scr_mem [SCROLL_BYTES];

    logic [7:0] vid_q_reg;
    logic [7:0] col_q_reg;
    logic [7:0] scr_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr.vid_we)
        begin
            vid_mem[wr.addr[VID_AW-1:0]] <= wr.data;
        end
        if (wr.col_we)
        begin
            col_mem[wr.addr[COL_AW-1:0]] <= wr.data;
        end
        if (wr.scr_we)
        begin
            scr_mem[wr.addr[SCR_AW-1:0]] <= wr.data;
        end
        vid_q_reg <= vid_mem[raddr[VID_AW-1:0]];
        col_q_reg <= col_mem[raddr[COL_AW-1:0]];
        scr_q_reg <= scr_mem[raddr[SCR_AW-1:0]];
    end

    assign rd.vid_q = vid_q_reg;
    assign rd.col_q = col_q_reg;
    assign rd.scr_q = scr_q_reg;

endmodule

// File: hdl/vpa_regs.sv
// ----------------------------------------------------------------------------
// Video port register file
// Control registers with fixed taps for increment and DMA setup.
// ----------------------------------------------------------------------------
module vpa_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  vpa_pkg::reg_wr_t  wr,
    output vpa_pkg::reg_tap_t taps
);
    import vpa_pkg::*;

    logic [7:0] file_reg [REGISTER_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                file_reg[i] <= 8'h00;
            end
        end
        else if (wr.we && (int'(wr.idx) < REGISTER_COUNT))
        begin
            file_reg[wr.idx[REG_AW-1:0]] <= wr.data;
        end
    end

    assign taps.inc  = file_reg[REG_INC];
    assign taps.len  = {file_reg[REG_LEN_HI], file_reg[REG_LEN_LO]};
    assign taps.src  = {file_reg[REG_SRC_MID][6:0], file_reg[REG_SRC_LO], 1'b0};
    assign taps.mode = file_reg[REG_SRC_HI][7:6];

endmodule
